// ===== rtl/spfd_pkg.sv =====
// ----------------------------------------------------------------------------
// spfd_pkg
// Shared types, constants, microcode ROM and saturation helpers for the
// stereo ping-pong feedback delay.
// ----------------------------------------------------------------------------
`default_nettype none

package spfd_pkg;

	// sample and state formats
	localparam int SAMPLE_W   = 24;
	localparam int STATE_FRAC = 6;
	localparam int X_W        = SAMPLE_W + STATE_FRAC;
	localparam int ST_W       = 32;
	localparam int BL_W       = 33;
	localparam int OPA_W      = 35;
	localparam int OPB_W      = 18;
	localparam int ACC_W      = OPA_W + OPB_W;

	// delay memory
	localparam int MAX_DELAY = 131072;
	localparam int ADDR_W    = $clog2(MAX_DELAY);
	localparam int DLY_W     = 17;

	// gains, unsigned Q1.16
	localparam int GAIN_W   = 17;
	localparam int UNITY    = 65536;
	localparam int FB_CAP   = 62259;
	localparam int MIX_SH   = 16;
	localparam int FB_SH    = 16 + STATE_FRAC;

	// configuration port
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;
	localparam int IDX_W   = 3;

	// microcode
	localparam int STEP_W = 5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ST_W-1:0]     st_t;
	typedef logic signed [BL_W-1:0]     bl_t;
	typedef logic signed [OPA_W-1:0]    opa_t;
	typedef logic signed [OPB_W-1:0]    opb_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [DLY_W-1:0]           dly_t;
	typedef logic [GAIN_W-1:0]          gain_t;
	typedef logic [STEP_W-1:0]          step_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLE   = 3'd0,
		REG_DLY_L    = 3'd1,
		REG_DLY_R    = 3'd2,
		REG_FEEDBACK = 3'd3,
		REG_WET      = 3'd4,
		REG_XTALK    = 3'd5,
		REG_HP_COEFF = 3'd6,
		REG_LP_COEFF = 3'd7
	} reg_idx_t;

	// effective (capped) gains handed to the datapath
	typedef struct packed {
		gain_t hc;
		gain_t lc;
		gain_t ct;
		gain_t ct_inv;
		gain_t fb;
		gain_t wet;
		gain_t wet_inv;
	} gains_t;

	// multiplier A operand
	typedef enum logic [3:0] {
		A_ZERO,
		A_HPL,    // xl - hl
		A_HPR,    // xr - hr
		A_LPL,    // xl - hl - ll
		A_LPR,    // xr - hr - lr
		A_LL,
		A_LR,
		A_BL,
		A_BR,
		A_IL,
		A_IR,
		A_DL,
		A_DR
	} asel_t;

	// multiplier B operand
	typedef enum logic [2:0] {
		B_ZERO,
		B_HC,
		B_LC,
		B_CT,
		B_CTI,
		B_FB,
		B_WET,
		B_WETI
	} bsel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LD16,  // product plus half LSB of a 16-bit drop
		ACC_LD22,  // product plus half LSB of a 22-bit drop
		ACC_ADD
	} accop_t;

	typedef enum logic [3:0] {
		WB_NONE,
		WB_HL,
		WB_HR,
		WB_LL,
		WB_LR,
		WB_BL,
		WB_BR,
		WB_OL,
		WB_OR,
		WB_WL,
		WB_WR,
		WB_PASS
	} wb_t;

	typedef enum logic [1:0] {
		J_NONE,
		J_OFF,     // taken when the effect is disabled
		J_ALWAYS
	} jmp_t;

	typedef struct packed {
		asel_t  asel;
		bsel_t  bsel;
		accop_t acc;
		wb_t    wb;
		logic   rd;
		logic   capd;
		logic   emit;
		logic   bump;
		jmp_t   jmp;
		step_t  target;
		logic   last;
	} uword_t;

	localparam uword_t UW_NOP = '{
		asel: A_ZERO, bsel: B_ZERO, acc: ACC_HOLD, wb: WB_NONE,
		rd: 1'b0, capd: 1'b0, emit: 1'b0, bump: 1'b0,
		jmp: J_NONE, target: '0, last: 1'b0
	};

	localparam step_t ST_EMIT = STEP_W'(21);
	localparam step_t ST_PASS = STEP_W'(22);

	localparam acc_t RND_MIX = acc_t'(2 ** (MIX_SH - 1));
	localparam acc_t RND_FB  = acc_t'(2 ** (FB_SH - 1));

	// Microprogram. An operand pair picked at a step passes through the operand
	// registers and the product register into the accumulator, then is written back.
	function automatic uword_t ucode_word(input step_t s);
		uword_t w;
		w = UW_NOP;
		unique case (s)
			STEP_W'(0): begin
				w.rd = 1'b1; w.jmp = J_OFF; w.target = ST_PASS;
			end
			STEP_W'(1): begin
				w.capd = 1'b1;
			end
			STEP_W'(2): begin
				w.asel = A_HPL; w.bsel = B_HC;
			end
			STEP_W'(3): begin
				w.asel = A_HPR; w.bsel = B_HC;
			end
			STEP_W'(4): begin
				w.asel = A_IL; w.bsel = B_WETI; w.acc = ACC_LD16;
			end
			STEP_W'(5): begin
				w.asel = A_DL; w.bsel = B_WET; w.acc = ACC_LD16; w.wb = WB_HL;
			end
			STEP_W'(6): begin
				w.asel = A_LPL; w.bsel = B_LC; w.acc = ACC_LD16; w.wb = WB_HR;
			end
			STEP_W'(7): begin
				w.asel = A_LPR; w.bsel = B_LC; w.acc = ACC_ADD;
			end
			STEP_W'(8): begin
				w.asel = A_IR; w.bsel = B_WETI; w.acc = ACC_LD16; w.wb = WB_OL;
			end
			STEP_W'(9): begin
				w.asel = A_DR; w.bsel = B_WET; w.acc = ACC_LD16; w.wb = WB_LL;
			end
			STEP_W'(10): begin
				w.asel = A_LL; w.bsel = B_CTI; w.acc = ACC_LD16; w.wb = WB_LR;
			end
			STEP_W'(11): begin
				w.asel = A_LR; w.bsel = B_CT; w.acc = ACC_ADD;
			end
			STEP_W'(12): begin
				w.asel = A_LR; w.bsel = B_CTI; w.acc = ACC_LD16; w.wb = WB_OR;
			end
			STEP_W'(13): begin
				w.asel = A_LL; w.bsel = B_CT; w.acc = ACC_ADD;
			end
			STEP_W'(14): begin
				w.acc = ACC_LD16; w.wb = WB_BL;
			end
			STEP_W'(15): begin
				w.asel = A_BL; w.bsel = B_FB; w.acc = ACC_ADD;
			end
			STEP_W'(16): begin
				w.wb = WB_BR;
			end
			STEP_W'(17): begin
				w.asel = A_BR; w.bsel = B_FB; w.acc = ACC_LD22;
			end
			STEP_W'(18): begin
				w.wb = WB_WL;
			end
			STEP_W'(19): begin
				w.acc = ACC_LD22;
			end
			STEP_W'(20): begin
				w.wb = WB_WR; w.bump = 1'b1;
			end
			ST_EMIT: begin
				w.emit = 1'b1; w.last = 1'b1;
			end
			ST_PASS: begin
				w.wb = WB_PASS; w.jmp = J_ALWAYS; w.target = ST_EMIT;
			end
			default: begin
				w = UW_NOP;
			end
		endcase
		return w;
	endfunction

	function automatic st_t sat_st(input acc_t v);
		acc_t hi;
		acc_t lo;
		hi = acc_t'($signed({1'b0, {(ST_W - 1){1'b1}}}));
		lo = ~hi;
		if (v > hi) begin
			return hi[ST_W-1:0];
		end else if (v < lo) begin
			return lo[ST_W-1:0];
		end
		return v[ST_W-1:0];
	endfunction

	function automatic sample_t sat_smp(input acc_t v);
		acc_t hi;
		acc_t lo;
		hi = acc_t'($signed({1'b0, {(SAMPLE_W - 1){1'b1}}}));
		lo = ~hi;
		if (v > hi) begin
			return hi[SAMPLE_W-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_W-1:0];
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/spfd_seq.sv =====
// ----------------------------------------------------------------------------
// spfd_seq
// Step counter and microcode ROM; issues one control word per cycle while running, except while the emit step waits.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            enable,
	input  wire logic            out_busy,
	output spfd_pkg::uword_t     ctl,
	output logic                 idle
);
	import spfd_pkg::*;

	logic   busy_q;
	step_t  step_q;
	uword_t word;
	logic   hold;
	logic   go;
	logic   busy_d;
	step_t  step_d;
	logic   taken;

	assign word = ucode_word(step_q);
	// only the emit step waits, for room in the output register
	assign hold = word.emit && out_busy;
	assign go   = busy_q && !hold;
	assign ctl  = go ? word : UW_NOP;
	assign idle = !busy_q;

	always_comb begin
		taken  = 1'b0;
		busy_d = busy_q;
		step_d = step_q;
		unique case (word.jmp)
			J_OFF:    taken = !enable;
			J_ALWAYS: taken = 1'b1;
			default:  taken = 1'b0;
		endcase
		if (!busy_q) begin
			if (start) begin
				busy_d = 1'b1;
				step_d = '0;
			end
		end else if (go) begin
			if (word.last) begin
				busy_d = 1'b0;
			end else if (taken) begin
				step_d = word.target;
			end else begin
				step_d = step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spfd_lines.sv =====
// ----------------------------------------------------------------------------
// spfd_lines
// Left and right delay memories, shared write position and fill tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_lines (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spfd_pkg::uword_t  ctl,
	input  wire spfd_pkg::dly_t    dly_l,
	input  wire spfd_pkg::dly_t    dly_r,
	input  wire spfd_pkg::sample_t wdata,
	output spfd_pkg::sample_t      dl,
	output spfd_pkg::sample_t      dr
);
	import spfd_pkg::*;

	logic [SAMPLE_W-1:0] mem_l [MAX_DELAY];
	logic [SAMPLE_W-1:0] mem_r [MAX_DELAY];

	addr_t   wi_q;
	logic    wrap_q;
	addr_t   ra_l;
	addr_t   ra_r;
	sample_t rd_l_q;
	sample_t rd_r_q;
	logic    vld_l_q;
	logic    vld_r_q;

	function automatic addr_t clamp_dly(input dly_t d);
		if (d == '0) begin
			return ADDR_W'(1);
		end else if (d > DLY_W'(MAX_DELAY - 1)) begin
			return ADDR_W'(MAX_DELAY - 1);
		end
		return ADDR_W'(d);
	endfunction

	assign ra_l = wi_q - clamp_dly(dly_l);
	assign ra_r = wi_q - clamp_dly(dly_r);

	// an entry never written since reset reads as zero
	assign dl = vld_l_q ? rd_l_q : '0;
	assign dr = vld_r_q ? rd_r_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q   <= '0;
			wrap_q <= 1'b0;
		end else if (ctl.bump) begin
			if (wi_q == ADDR_W'(MAX_DELAY - 1)) begin
				wi_q   <= '0;
				wrap_q <= 1'b1;
			end else begin
				wi_q <= wi_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wb == WB_WL) begin
			mem_l[wi_q] <= wdata;
		end
		if (ctl.rd) begin
			rd_l_q  <= mem_l[ra_l];
			vld_l_q <= wrap_q || (ra_l < wi_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wb == WB_WR) begin
			mem_r[wi_q] <= wdata;
		end
		if (ctl.rd) begin
			rd_r_q  <= mem_r[ra_r];
			vld_r_q <= wrap_q || (ra_r < wi_q);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spfd_dp.sv =====
// ----------------------------------------------------------------------------
// spfd_dp
// Shared multiply-accumulate datapath with filter states and work registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spfd_pkg::uword_t  ctl,
	input  wire spfd_pkg::gains_t  gains,
	input  wire logic              load_in,
	input  wire spfd_pkg::sample_t in_l,
	input  wire spfd_pkg::sample_t in_r,
	input  wire spfd_pkg::sample_t dl,
	input  wire spfd_pkg::sample_t dr,
	output spfd_pkg::sample_t      wdata,
	output spfd_pkg::sample_t      out_l,
	output spfd_pkg::sample_t      out_r
);
	import spfd_pkg::*;

	st_t     hl_q, hr_q, ll_q, lr_q;
	sample_t il_q, ir_q, dl_q, dr_q;
	sample_t ol_q, or_q;
	bl_t     bl_q, br_q;
	opa_t    opa_q;
	opb_t    opb_q;
	acc_t    prod_q;
	acc_t    acc_q;

	logic signed [X_W-1:0] xl, xr;
	opa_t opa_d;
	opb_t opb_d;
	acc_t sh_mix;
	acc_t sh_fb;

	assign xl = $signed({dl_q, {STATE_FRAC{1'b0}}});
	assign xr = $signed({dr_q, {STATE_FRAC{1'b0}}});

	assign sh_mix = acc_q >>> MIX_SH;
	assign sh_fb  = acc_q >>> FB_SH;

	assign wdata = (ctl.wb == WB_WR) ? sat_smp(acc_t'(ir_q) + sh_fb)
	                                 : sat_smp(acc_t'(il_q) + sh_fb);
	assign out_l = ol_q;
	assign out_r = or_q;

	always_comb begin
		unique case (ctl.asel)
			A_HPL:   opa_d = opa_t'(xl) - opa_t'(hl_q);
			A_HPR:   opa_d = opa_t'(xr) - opa_t'(hr_q);
			A_LPL:   opa_d = opa_t'(xl) - opa_t'(hl_q) - opa_t'(ll_q);
			A_LPR:   opa_d = opa_t'(xr) - opa_t'(hr_q) - opa_t'(lr_q);
			A_LL:    opa_d = opa_t'(ll_q);
			A_LR:    opa_d = opa_t'(lr_q);
			A_BL:    opa_d = opa_t'(bl_q);
			A_BR:    opa_d = opa_t'(br_q);
			A_IL:    opa_d = opa_t'(il_q);
			A_IR:    opa_d = opa_t'(ir_q);
			A_DL:    opa_d = opa_t'(dl_q);
			A_DR:    opa_d = opa_t'(dr_q);
			default: opa_d = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.bsel)
			B_HC:    opb_d = $signed({1'b0, gains.hc});
			B_LC:    opb_d = $signed({1'b0, gains.lc});
			B_CT:    opb_d = $signed({1'b0, gains.ct});
			B_CTI:   opb_d = $signed({1'b0, gains.ct_inv});
			B_FB:    opb_d = $signed({1'b0, gains.fb});
			B_WET:   opb_d = $signed({1'b0, gains.wet});
			B_WETI:  opb_d = $signed({1'b0, gains.wet_inv});
			default: opb_d = '0;
		endcase
	end

	// filter states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= '0;
			hr_q <= '0;
			ll_q <= '0;
			lr_q <= '0;
		end else begin
			if (ctl.wb == WB_HL) hl_q <= sat_st(acc_t'(hl_q) + sh_mix);
			if (ctl.wb == WB_HR) hr_q <= sat_st(acc_t'(hr_q) + sh_mix);
			if (ctl.wb == WB_LL) ll_q <= sat_st(acc_t'(ll_q) + sh_mix);
			if (ctl.wb == WB_LR) lr_q <= sat_st(acc_t'(lr_q) + sh_mix);
		end
	end

	always_ff @(posedge clk) begin
		opa_q  <= opa_d;
		opb_q  <= opb_d;
		prod_q <= opa_q * opb_q;

		unique case (ctl.acc)
			ACC_LD16: acc_q <= prod_q + RND_MIX;
			ACC_LD22: acc_q <= prod_q + RND_FB;
			ACC_ADD:  acc_q <= acc_q + prod_q;
			default:  acc_q <= acc_q;
		endcase

		if (load_in) begin
			il_q <= in_l;
			ir_q <= in_r;
		end
		if (ctl.capd) begin
			dl_q <= dl;
			dr_q <= dr;
		end

		unique case (ctl.wb)
			WB_BL:   bl_q <= bl_t'(sh_mix);
			WB_BR:   br_q <= bl_t'(sh_mix);
			WB_OL:   ol_q <= sat_smp(sh_mix);
			WB_OR:   or_q <= sat_smp(sh_mix);
			WB_PASS: begin
				ol_q <= il_q;
				or_q <= ir_q;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/stereo_pingpong_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// stereo_pingpong_feedback_delay
// Stereo ping-pong delay with high-pass/low-pass filtered, cross-blended
// feedback and dry/wet output mix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one Q1.23 stereo pair per
//   request; output channel (out_valid/out_ready) returns one output pair per
//   request, in order. Gains and delays sit in APB registers at 4*index.
// Sequencing:
//   Effect on: the whole microprogram runs for each pair. Effect off: it
//   jumps from the read step to a pass-through step, then to the emit step.
//   A new request is taken only once the program for the last one is done.
//   One shared 35x18 multiplier and one accumulator do all 14 products per pair.
// Stalls:
//   A finished pair waits in the output register; the next request is taken
//   meanwhile. The program only holds at its final step while that register
//   is still occupied.
// Reset:
//   Registers go to their defaults, filter states and write position to zero.
//   Delay memory is not swept: a fill mark makes never-written entries read
//   as zero, so the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_pingpong_feedback_delay (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [spfd_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [spfd_pkg::DATA_W-1:0]     pwdata,
	output logic      [spfd_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	// input samples
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire spfd_pkg::sample_t               in_left,
	input  wire spfd_pkg::sample_t               in_right,
	// output samples
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output spfd_pkg::sample_t                    out_left,
	output spfd_pkg::sample_t                    out_right
);
	import spfd_pkg::*;

	// configuration registers
	logic             en_q;
	dly_t             dly_l_q;
	dly_t             dly_r_q;
	logic [15:0]      fb_q;
	gain_t            wet_q;
	gain_t            ct_q;
	logic [15:0]      hc_q;
	logic [15:0]      lc_q;

	reg_idx_t         idx;
	logic             wr_en;

	gains_t           gains;
	gain_t            ct_eff;
	gain_t            wet_eff;

	uword_t           ctl;
	logic             idle;
	logic             accept;
	logic             out_busy;
	sample_t          dl, dr;
	sample_t          wdata;
	sample_t          mix_l, mix_r;

	logic             out_valid_q;
	sample_t          out_left_q;
	sample_t          out_right_q;

	// ---------------- APB register file ----------------
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			dly_l_q <= DLY_W'(12000);
			dly_r_q <= DLY_W'(12000);
			fb_q    <= 16'd26214;
			wet_q   <= GAIN_W'(19661);
			ct_q    <= GAIN_W'(65536);
			hc_q    <= 16'd500;
			lc_q    <= 16'd52000;
		end else if (wr_en) begin
			unique case (idx)
				REG_ENABLE:   en_q    <= pwdata[0];
				REG_DLY_L:    dly_l_q <= pwdata[DLY_W-1:0];
				REG_DLY_R:    dly_r_q <= pwdata[DLY_W-1:0];
				REG_FEEDBACK: fb_q    <= pwdata[15:0];
				REG_WET:      wet_q   <= pwdata[GAIN_W-1:0];
				REG_XTALK:    ct_q    <= pwdata[GAIN_W-1:0];
				REG_HP_COEFF: hc_q    <= pwdata[15:0];
				REG_LP_COEFF: lc_q    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ENABLE:   prdata = DATA_W'(en_q);
			REG_DLY_L:    prdata = DATA_W'(dly_l_q);
			REG_DLY_R:    prdata = DATA_W'(dly_r_q);
			REG_FEEDBACK: prdata = DATA_W'(fb_q);
			REG_WET:      prdata = DATA_W'(wet_q);
			REG_XTALK:    prdata = DATA_W'(ct_q);
			REG_HP_COEFF: prdata = DATA_W'(hc_q);
			REG_LP_COEFF: prdata = DATA_W'(lc_q);
			default:      prdata = '0;
		endcase
	end

	// effective gains: out-of-range settings are capped, not rejected
	assign ct_eff  = (ct_q > GAIN_W'(UNITY)) ? GAIN_W'(UNITY) : ct_q;
	assign wet_eff = (wet_q > GAIN_W'(UNITY)) ? GAIN_W'(UNITY) : wet_q;

	assign gains.hc      = GAIN_W'(hc_q);
	assign gains.lc      = GAIN_W'(lc_q);
	assign gains.ct      = ct_eff;
	assign gains.ct_inv  = GAIN_W'(UNITY) - ct_eff;
	assign gains.wet     = wet_eff;
	assign gains.wet_inv = GAIN_W'(UNITY) - wet_eff;
	assign gains.fb      = (fb_q > 16'(FB_CAP)) ? GAIN_W'(FB_CAP) : GAIN_W'(fb_q);

	// ---------------- handshake ----------------
	assign in_ready = idle;
	assign accept   = in_valid && in_ready;
	// output register full and not being drained this cycle
	assign out_busy = out_valid_q && !out_ready;

	// ---------------- sequencer, datapath, memories ----------------
	spfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.enable   (en_q),
		.out_busy (out_busy),
		.ctl      (ctl),
		.idle     (idle)
	);

	spfd_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.gains   (gains),
		.load_in (accept),
		.in_l    (in_left),
		.in_r    (in_right),
		.dl      (dl),
		.dr      (dr),
		.wdata   (wdata),
		.out_l   (mix_l),
		.out_r   (mix_r)
	);

	spfd_lines u_lines (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.dly_l  (dly_l_q),
		.dly_r  (dly_r_q),
		.wdata  (wdata),
		.dl     (dl),
		.dr     (dr)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_left_q  <= mix_l;
			out_right_q <= mix_r;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;

endmodule

`default_nettype wire
